@@ design/tlpm_pkg.sv @@
// Package for the polled terminal link master: payload structs, codes, reset values.
// No dependencies.
`default_nettype none
package tlpm_pkg;

  localparam int PayloadBytesDefault = 256;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_octet;
    logic       line_signal;
    logic       loop_in_sync;
    logic       tx_queue_empty;
    logic       tx_idle;
    logic       in_call;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [1:0]  link_event;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [8:0]  payload_index;
    logic [1:0]  packet_result;
    logic [1:0]  verbose_state;
    logic [3:0]  link_state;
    logic [15:0] fault_count;
    logic [15:0] timeout_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  idle_ticks;
    logic [7:0]  ack_timeout;
    logic [7:0]  octet_timeout;
    logic [7:0]  fast_poll_timeout;
    logic [11:0] transmit_timeout;
    logic [11:0] sync_wait_timeout;
    logic [7:0]  status_func_code;
    logic [7:0]  test_result_func_code;
  } cfg_t;

  // request kinds
  localparam logic [1:0] REQ_OCTET = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_LINE  = 2'd2;

  // protocol states
  localparam logic [3:0] ST_OFF  = 4'd0;
  localparam logic [3:0] ST_SYNC = 4'd1;
  localparam logic [3:0] ST_REST = 4'd2;
  localparam logic [3:0] ST_ASK  = 4'd3;
  localparam logic [3:0] ST_LEN2 = 4'd4;
  localparam logic [3:0] ST_BODY = 4'd5;
  localparam logic [3:0] ST_ACKW = 4'd6;
  localparam logic [3:0] ST_SEND = 4'd7;
  localparam logic [3:0] ST_INQ  = 4'd8;

  // actions
  localparam logic [3:0] ACT_NONE    = 4'd0;
  localparam logic [3:0] ACT_POS_ACK = 4'd1;
  localparam logic [3:0] ACT_NEG_ACK = 4'd2;
  localparam logic [3:0] ACT_POLL    = 4'd3;
  localparam logic [3:0] ACT_START   = 4'd4;
  localparam logic [3:0] ACT_RESTART = 4'd5;
  localparam logic [3:0] ACT_ERASE   = 4'd6;
  localparam logic [3:0] ACT_PWR_UP  = 4'd7;
  localparam logic [3:0] ACT_PWR_DN  = 4'd8;
  localparam logic [3:0] ACT_FREEZE  = 4'd9;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_SYNC = 2'd1;
  localparam logic [1:0] EV_LOST = 2'd2;

  localparam logic [1:0] PR_NONE = 2'd0;
  localparam logic [1:0] PR_DONE = 2'd1;
  localparam logic [1:0] PR_OVFL = 2'd2;
  localparam logic [1:0] PR_DUP  = 2'd3;

  localparam logic [1:0] VS_DOWN   = 2'd0;
  localparam logic [1:0] VS_HALF   = 2'd1;
  localparam logic [1:0] VS_UP     = 2'd2;
  localparam logic [1:0] VS_FAULTY = 2'd3;

  // link timer constants
  localparam logic [11:0] T_OFF_WAIT  = 12'd500;
  localparam logic [11:0] T_LINE_WAIT = 12'd200;

  // framing constants
  localparam logic [7:0] LEN_LONG0 = 8'h80;
  localparam logic [7:0] LEN_LONG1 = 8'h81;
  localparam logic [7:0] LEN_MAXS  = 8'h7F;
  localparam logic [7:0] ACK_OCTET = 8'hAA;
  localparam logic [7:0] TEST_MARK = 8'h7F;
  localparam logic [8:0] LEN_LIMIT = 9'd305;

  // register indexes
  localparam logic [2:0] REG_POLL  = 3'd0;
  localparam logic [2:0] REG_ACK   = 3'd1;
  localparam logic [2:0] REG_OCTET = 3'd2;
  localparam logic [2:0] REG_FAST  = 3'd3;
  localparam logic [2:0] REG_TX    = 3'd4;
  localparam logic [2:0] REG_SYNCW = 3'd5;
  localparam logic [2:0] REG_STAT  = 3'd6;
  localparam logic [2:0] REG_TEST  = 3'd7;

  localparam cfg_t CFG_RESET = '{
    idle_ticks: 8'd12, ack_timeout: 8'd7, octet_timeout: 8'd3,
    fast_poll_timeout: 8'd2, transmit_timeout: 12'd1000,
    sync_wait_timeout: 12'd2000, status_func_code: 8'd0,
    test_result_func_code: 8'd0};

endpackage
`default_nettype wire

@@ design/tlpm_regs.sv @@
// Configuration register file with APB-style access for the link master.
// Depends on tlpm_pkg.
`default_nettype none
module tlpm_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output tlpm_pkg::cfg_t     cfg
);

  logic [2:0] idx;
  assign idx    = paddr[4:2];
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= tlpm_pkg::CFG_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        tlpm_pkg::REG_POLL:  cfg.idle_ticks            <= pwdata[7:0];
        tlpm_pkg::REG_ACK:   cfg.ack_timeout           <= pwdata[7:0];
        tlpm_pkg::REG_OCTET: cfg.octet_timeout         <= pwdata[7:0];
        tlpm_pkg::REG_FAST:  cfg.fast_poll_timeout     <= pwdata[7:0];
        tlpm_pkg::REG_TX:    cfg.transmit_timeout      <= pwdata[11:0];
        tlpm_pkg::REG_SYNCW: cfg.sync_wait_timeout     <= pwdata[11:0];
        tlpm_pkg::REG_STAT:  cfg.status_func_code      <= pwdata[7:0];
        tlpm_pkg::REG_TEST:  cfg.test_result_func_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      tlpm_pkg::REG_POLL:  prdata = {24'd0, cfg.idle_ticks};
      tlpm_pkg::REG_ACK:   prdata = {24'd0, cfg.ack_timeout};
      tlpm_pkg::REG_OCTET: prdata = {24'd0, cfg.octet_timeout};
      tlpm_pkg::REG_FAST:  prdata = {24'd0, cfg.fast_poll_timeout};
      tlpm_pkg::REG_TX:    prdata = {20'd0, cfg.transmit_timeout};
      tlpm_pkg::REG_SYNCW: prdata = {20'd0, cfg.sync_wait_timeout};
      tlpm_pkg::REG_STAT:  prdata = {24'd0, cfg.status_func_code};
      tlpm_pkg::REG_TEST:  prdata = {24'd0, cfg.test_result_func_code};
      default:             prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

@@ design/telephone_link_poll_master_unit.sv @@
// Top level of the polled terminal link master: protocol engine and output stage.
// Depends on tlpm_pkg and tlpm_regs.
//
// Usage: one input channel (in_valid/in_stall/in_data) carries events: a
// received octet, a millisecond tick or a line-status update. Each event
// yields exactly one result beat on the output channel (out_valid/out_stall/
// out_data): action, link event, an optional payload byte with its index,
// packet result, and the link status after the event.
// The event is processed in the accept cycle and its result sits in the
// output register from the next edge on. Throughput is one event per cycle
// while the output is not stalled; the whole protocol step is one pass of
// combinational logic from the state registers into the result register.
// When the receiver stalls, the result holds and the input stalls only while
// the output register is full and not drained, so a new event enters on the
// same edge the old result leaves.
// Reset (rst, synchronous) puts the link in the disabled state with the timer
// disarmed, all counters at zero and the registers at their defaults.
// Configuration goes through the APB-style port; write only while idle.
`default_nettype none
module telephone_link_poll_master_unit #(
  parameter int PAYLOAD_BYTES = tlpm_pkg::PayloadBytesDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire tlpm_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output tlpm_pkg::out_item_t      out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  localparam int SW = $clog2(PAYLOAD_BYTES + 1);

  tlpm_pkg::cfg_t cfg;

  tlpm_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // protocol state
  logic [3:0]  pstate, pstate_next;
  logic [11:0] timer, timer_next;
  logic        armed, armed_next;
  logic [8:0]  exp_len, exp_len_next;
  logic [8:0]  rcvd, rcvd_next;
  logic [SW-1:0] stored, stored_next;
  logic [7:0]  rsum, rsum_next;
  logic        ovfl, ovfl_next;
  logic [7:0]  head [4];
  logic [7:0]  head_next [4];
  logic [2:0]  last_seq, last_seq_next;
  logic [7:0]  last_sum, last_sum_next;
  logic        enh, enh_next;
  logic [15:0] faults, faults_next;
  logic [15:0] tmos, tmos_next;
  logic [1:0]  level, level_next;

  tlpm_pkg::out_item_t res;

  logic accept;
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // one event step
  always_comb begin
    logic [7:0]  b;
    logic        f_up, f_dn, t_up, t_dn;
    logic        go_en;
    logic [3:0]  go_st;
    logic [11:0] go_t;
    logic [11:0] succ_t;
    logic [8:0]  len2;
    logic [8:0]  rcvd_inc;
    logic [7:0]  csum;
    logic [2:0]  seq;
    logic [11:0] tdec;
    b        = in_data.rx_octet;
    f_up = 1'b0; f_dn = 1'b0; t_up = 1'b0; t_dn = 1'b0;
    go_en = 1'b0; go_st = pstate; go_t = 12'd0;
    succ_t   = {4'd0, enh ? cfg.fast_poll_timeout : cfg.idle_ticks};
    len2     = exp_len + {1'b0, b};
    rcvd_inc = rcvd + 9'd1;
    csum     = rsum - 8'd1;
    seq      = head[0][3:1];
    tdec     = (timer != 12'd0) ? timer - 12'd1 : timer;

    pstate_next = pstate; timer_next = timer; armed_next = armed;
    exp_len_next = exp_len; rcvd_next = rcvd; stored_next = stored;
    rsum_next = rsum; ovfl_next = ovfl; head_next = head;
    last_seq_next = last_seq; last_sum_next = last_sum; enh_next = enh;
    level_next = level;
    res = '0;

    case (in_data.req_type)
      tlpm_pkg::REQ_OCTET: begin
        case (pstate)
          tlpm_pkg::ST_REST, tlpm_pkg::ST_SEND: f_up = 1'b1;
          tlpm_pkg::ST_ASK: begin
            t_dn = 1'b1;
            if (b == 8'd0 || b == 8'd1) begin
              f_dn = 1'b1; enh_next = b[0];
              go_en = 1'b1; go_st = tlpm_pkg::ST_REST; go_t = {4'd0, cfg.idle_ticks};
            end else if (b >= 8'd4 && b <= tlpm_pkg::LEN_MAXS) begin
              exp_len_next = {1'b0, b};
              stored_next = '0; ovfl_next = 1'b0; rcvd_next = 9'd1; rsum_next = b;
              go_en = 1'b1; go_st = tlpm_pkg::ST_BODY; go_t = {4'd0, cfg.octet_timeout};
            end else if (b == tlpm_pkg::LEN_LONG0 || b == tlpm_pkg::LEN_LONG1) begin
              exp_len_next = {b[0], 8'd0};
              stored_next = '0; ovfl_next = 1'b0; rcvd_next = 9'd1; rsum_next = b;
              go_en = 1'b1; go_st = tlpm_pkg::ST_LEN2; go_t = {4'd0, cfg.octet_timeout};
            end else begin
              f_up = 1'b1;
              go_en = 1'b1; go_st = tlpm_pkg::ST_REST; go_t = {4'd0, cfg.idle_ticks};
            end
          end
          tlpm_pkg::ST_LEN2: begin
            t_dn = 1'b1;
            exp_len_next = len2;
            if (len2 >= 9'd5 && len2 < tlpm_pkg::LEN_LIMIT) begin
              rsum_next = rsum + b; rcvd_next = rcvd_inc;
              go_en = 1'b1; go_st = tlpm_pkg::ST_BODY; go_t = {4'd0, cfg.octet_timeout};
            end else begin
              f_up = 1'b1;
              go_en = 1'b1; go_st = tlpm_pkg::ST_REST; go_t = {4'd0, cfg.idle_ticks};
            end
          end
          tlpm_pkg::ST_BODY: begin
            t_dn = 1'b1;
            rcvd_next = rcvd_inc;
            if (rcvd_inc < exp_len) begin
              if (stored < SW'(PAYLOAD_BYTES)) begin
                if (stored < SW'(4)) head_next[stored[1:0]] = b;
                res.payload_valid = 1'b1;
                res.payload_byte  = b;
                res.payload_index = 9'(stored);
                stored_next = stored + SW'(1);
              end else begin
                ovfl_next = 1'b1;
              end
              rsum_next = rsum + b;
              go_en = 1'b1; go_st = tlpm_pkg::ST_BODY; go_t = {4'd0, cfg.octet_timeout};
            end else if (csum != b) begin
              f_up = 1'b1; res.action = tlpm_pkg::ACT_NEG_ACK;
              go_en = 1'b1; go_st = tlpm_pkg::ST_REST; go_t = {4'd0, cfg.idle_ticks};
            end else begin
              res.action = tlpm_pkg::ACT_POS_ACK;
              go_en = 1'b1; go_st = tlpm_pkg::ST_REST;
              if (seq == last_seq && (seq != 3'd0 || csum == last_sum)) begin
                f_up = 1'b1; f_dn = 1'b1;
                res.packet_result = tlpm_pkg::PR_DUP;
                go_t = {4'd0, cfg.idle_ticks};
              end else begin
                f_dn = 1'b1;
                last_seq_next = seq; last_sum_next = csum;
                go_t = succ_t;
                if (ovfl) begin
                  res.packet_result = tlpm_pkg::PR_OVFL;
                end else begin
                  res.packet_result = tlpm_pkg::PR_DONE;
                  if (head[1] == cfg.status_func_code) begin
                    if (!in_data.in_call) level_next = tlpm_pkg::VS_UP;
                  end else if (head[1] == cfg.test_result_func_code &&
                               head[2] == tlpm_pkg::TEST_MARK) begin
                    if (head[3] != 8'd0) level_next = tlpm_pkg::VS_FAULTY;
                  end
                end
              end
            end
          end
          tlpm_pkg::ST_ACKW: begin
            t_dn = 1'b1;
            go_en = 1'b1; go_st = tlpm_pkg::ST_REST;
            if (b == tlpm_pkg::ACK_OCTET) begin
              f_dn = 1'b1; res.action = tlpm_pkg::ACT_ERASE; go_t = succ_t;
            end else begin
              f_up = 1'b1; res.action = tlpm_pkg::ACT_RESTART;
              go_t = {4'd0, cfg.idle_ticks};
            end
          end
          tlpm_pkg::ST_INQ: res.action = tlpm_pkg::ACT_FREEZE;
          default: ;
        endcase
      end
      tlpm_pkg::REQ_TICK: begin
        if (pstate == tlpm_pkg::ST_SEND && in_data.tx_idle) begin
          go_en = 1'b1; go_st = tlpm_pkg::ST_ACKW; go_t = {4'd0, cfg.ack_timeout};
        end else if (armed) begin
          timer_next = tdec;
          if (tdec == 12'd0) begin
            armed_next = 1'b0;
            case (pstate)
              tlpm_pkg::ST_OFF: begin
                res.action = tlpm_pkg::ACT_PWR_UP; level_next = tlpm_pkg::VS_DOWN;
                go_en = 1'b1; go_st = tlpm_pkg::ST_SYNC; go_t = cfg.sync_wait_timeout;
              end
              tlpm_pkg::ST_SYNC: begin
                res.action = tlpm_pkg::ACT_PWR_DN; level_next = tlpm_pkg::VS_DOWN;
                go_en = 1'b1; go_st = tlpm_pkg::ST_OFF; go_t = tlpm_pkg::T_OFF_WAIT;
              end
              tlpm_pkg::ST_REST: begin
                go_en = 1'b1;
                if (in_data.tx_queue_empty) begin
                  res.action = tlpm_pkg::ACT_POLL;
                  go_st = tlpm_pkg::ST_ASK; go_t = {4'd0, cfg.ack_timeout};
                end else begin
                  res.action = tlpm_pkg::ACT_START;
                  go_st = tlpm_pkg::ST_SEND; go_t = cfg.transmit_timeout;
                end
              end
              tlpm_pkg::ST_ASK, tlpm_pkg::ST_LEN2, tlpm_pkg::ST_BODY: begin
                t_up = 1'b1;
                go_en = 1'b1; go_st = tlpm_pkg::ST_REST; go_t = {4'd0, cfg.idle_ticks};
              end
              tlpm_pkg::ST_ACKW: begin
                t_up = 1'b1; res.action = tlpm_pkg::ACT_RESTART;
                go_en = 1'b1; go_st = tlpm_pkg::ST_REST; go_t = {4'd0, cfg.idle_ticks};
              end
              default: res.action = tlpm_pkg::ACT_FREEZE;
            endcase
          end
        end
      end
      tlpm_pkg::REQ_LINE: begin
        if (pstate == tlpm_pkg::ST_OFF) begin
          if (in_data.line_signal) begin
            res.action = tlpm_pkg::ACT_PWR_UP; level_next = tlpm_pkg::VS_DOWN;
            go_en = 1'b1; go_st = tlpm_pkg::ST_SYNC; go_t = tlpm_pkg::T_LINE_WAIT;
          end
        end else if (pstate == tlpm_pkg::ST_SYNC) begin
          if (!in_data.line_signal) begin
            res.action = tlpm_pkg::ACT_PWR_DN; level_next = tlpm_pkg::VS_DOWN;
            go_en = 1'b1; go_st = tlpm_pkg::ST_OFF; go_t = tlpm_pkg::T_OFF_WAIT;
          end else if (in_data.loop_in_sync) begin
            res.link_event = tlpm_pkg::EV_SYNC; level_next = tlpm_pkg::VS_HALF;
            go_en = 1'b1; go_st = tlpm_pkg::ST_REST; go_t = tlpm_pkg::T_LINE_WAIT;
          end
        end else if (!in_data.loop_in_sync) begin
          res.link_event = tlpm_pkg::EV_LOST; level_next = tlpm_pkg::VS_DOWN;
          go_en = 1'b1;
          if (in_data.line_signal) begin
            go_st = tlpm_pkg::ST_SYNC; go_t = tlpm_pkg::T_LINE_WAIT;
          end else begin
            res.action = tlpm_pkg::ACT_PWR_DN;
            go_st = tlpm_pkg::ST_OFF; go_t = tlpm_pkg::T_OFF_WAIT;
          end
        end
      end
      default: ;
    endcase

    if (go_en) begin
      pstate_next = go_st; timer_next = go_t; armed_next = 1'b1;
    end

    // saturating counters; duplicate path steps down then up
    faults_next = faults;
    if (f_dn && faults != 16'd0) faults_next = faults_next - 16'd1;
    if (f_up && faults_next != 16'hFFFF) faults_next = faults_next + 16'd1;
    tmos_next = tmos;
    if (t_dn && tmos != 16'd0) tmos_next = tmos - 16'd1;
    if (t_up && tmos != 16'hFFFF) tmos_next = tmos + 16'd1;

    res.verbose_state = level_next;
    res.link_state    = pstate_next;
    res.fault_count   = faults_next;
    res.timeout_count = tmos_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= tlpm_pkg::ST_OFF; timer <= '0; armed <= 1'b0;
      exp_len <= '0; rcvd <= '0; stored <= '0; rsum <= '0; ovfl <= 1'b0;
      head <= '{default: 8'd0};
      last_seq <= '0; last_sum <= '0; enh <= 1'b0;
      faults <= '0; tmos <= '0; level <= tlpm_pkg::VS_DOWN;
    end else if (accept) begin
      pstate <= pstate_next; timer <= timer_next; armed <= armed_next;
      exp_len <= exp_len_next; rcvd <= rcvd_next; stored <= stored_next;
      rsum <= rsum_next; ovfl <= ovfl_next; head <= head_next;
      last_seq <= last_seq_next; last_sum <= last_sum_next; enh <= enh_next;
      faults <= faults_next; tmos <= tmos_next; level <= level_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for the polled terminal link master: a link predictor, a scoreboard
// and random and directed event traffic. Depends on tlpm_pkg and the top level.
`timescale 1ns / 1ps

class link_scoreboard;
  // predictor state
  tlpm_pkg::cfg_t cfg;
  logic [3:0]   pstate;
  logic [11:0]  timer;
  bit           armed;
  logic [8:0]   exp_len, octets;
  int unsigned  stored;
  logic [7:0]   rsum;
  bit           ovfl;
  logic [7:0]   head [4];
  logic [2:0]   last_seq;
  logic [7:0]   last_sum;
  bit           enhanced;
  int unsigned  faults, tmos;
  logic [1:0]   vlevel;
  tlpm_pkg::out_item_t pending [$];
  tlpm_pkg::out_item_t r;
  int           errors;
  int           checked;
  int           payload_beats, packets_done;

  function void reset_state();
    cfg = tlpm_pkg::CFG_RESET;
    pstate = tlpm_pkg::ST_OFF; timer = '0; armed = 0;
    exp_len = '0; octets = '0; stored = 0; rsum = '0; ovfl = 0;
    foreach (head[i]) head[i] = '0;
    last_seq = '0; last_sum = '0; enhanced = 0;
    faults = 0; tmos = 0; vlevel = tlpm_pkg::VS_DOWN;
  endfunction

  function void go(logic [3:0] s, logic [11:0] t);
    pstate = s; timer = t; armed = 1;
  endfunction

  function void fault_up();   if (faults < 65535) faults++; endfunction
  function void fault_down(); if (faults > 0) faults--; endfunction
  function void tmo_up();     if (tmos < 65535) tmos++; endfunction
  function void tmo_down();   if (tmos > 0) tmos--; endfunction

  function logic [11:0] rest_time();
    return 12'(enhanced ? cfg.fast_poll_timeout : cfg.idle_ticks);
  endfunction

  function logic [11:0] idle_time();
    return 12'(cfg.idle_ticks);
  endfunction

  function void new_frame(logic [7:0] b);
    stored = 0; ovfl = 0; octets = 9'd1; rsum = b;
  endfunction

  function void close_frame(logic [7:0] b, bit call);
    logic [7:0] sum;
    logic [2:0] seq;
    sum = rsum - 8'd1;
    if (sum != b) begin
      fault_up(); r.action = tlpm_pkg::ACT_NEG_ACK; go(tlpm_pkg::ST_REST, idle_time());
      return;
    end
    fault_down();
    r.action = tlpm_pkg::ACT_POS_ACK;
    seq = head[0][3:1];
    if (seq == last_seq && (seq != 0 || sum == last_sum)) begin
      fault_up(); r.packet_result = tlpm_pkg::PR_DUP; go(tlpm_pkg::ST_REST, idle_time());
      return;
    end
    last_seq = seq; last_sum = sum;
    go(tlpm_pkg::ST_REST, rest_time());
    if (ovfl) begin
      r.packet_result = tlpm_pkg::PR_OVFL;
      return;
    end
    r.packet_result = tlpm_pkg::PR_DONE;
    packets_done++;
    if (head[1] == cfg.status_func_code) begin
      if (!call) vlevel = tlpm_pkg::VS_UP;
    end else if (head[1] == cfg.test_result_func_code && head[2] == tlpm_pkg::TEST_MARK) begin
      if (head[3] != 0) vlevel = tlpm_pkg::VS_FAULTY;
    end
  endfunction

  function void octet(logic [7:0] b, bit call);
    case (pstate)
      tlpm_pkg::ST_REST, tlpm_pkg::ST_SEND: fault_up();
      tlpm_pkg::ST_ASK: begin
        tmo_down();
        if (b == 8'h00 || b == 8'h01) begin
          fault_down(); enhanced = b[0]; go(tlpm_pkg::ST_REST, idle_time());
        end else if (b >= 8'd4 && b <= tlpm_pkg::LEN_MAXS) begin
          exp_len = {1'b0, b}; new_frame(b);
          go(tlpm_pkg::ST_BODY, 12'(cfg.octet_timeout));
        end else if (b == tlpm_pkg::LEN_LONG0 || b == tlpm_pkg::LEN_LONG1) begin
          exp_len = {b[0], 8'h00}; new_frame(b);
          go(tlpm_pkg::ST_LEN2, 12'(cfg.octet_timeout));
        end else begin
          fault_up(); go(tlpm_pkg::ST_REST, idle_time());
        end
      end
      tlpm_pkg::ST_LEN2: begin
        tmo_down();
        exp_len = exp_len + {1'b0, b};
        if (exp_len >= 9'd5 && exp_len < tlpm_pkg::LEN_LIMIT) begin
          rsum = rsum + b; octets++; go(tlpm_pkg::ST_BODY, 12'(cfg.octet_timeout));
        end else begin
          fault_up(); go(tlpm_pkg::ST_REST, idle_time());
        end
      end
      tlpm_pkg::ST_BODY: begin
        tmo_down();
        octets = octets + 9'd1;
        if (octets < exp_len) begin
          if (stored < tlpm_pkg::PayloadBytesDefault) begin
            if (stored < 4) head[stored[1:0]] = b;
            r.payload_valid = 1; r.payload_byte = b; r.payload_index = stored[8:0];
            stored++;
          end else ovfl = 1;
          rsum = rsum + b;
          go(tlpm_pkg::ST_BODY, 12'(cfg.octet_timeout));
        end else close_frame(b, call);
      end
      tlpm_pkg::ST_ACKW: begin
        tmo_down();
        if (b == tlpm_pkg::ACK_OCTET) begin
          fault_down(); r.action = tlpm_pkg::ACT_ERASE; go(tlpm_pkg::ST_REST, rest_time());
        end else begin
          fault_up(); r.action = tlpm_pkg::ACT_RESTART; go(tlpm_pkg::ST_REST, idle_time());
        end
      end
      tlpm_pkg::ST_INQ: r.action = tlpm_pkg::ACT_FREEZE;
      default: ;
    endcase
  endfunction

  function void tick(bit qempty, bit txidle);
    if (pstate == tlpm_pkg::ST_SEND && txidle) begin
      go(tlpm_pkg::ST_ACKW, 12'(cfg.ack_timeout));
      return;
    end
    if (!armed) return;
    if (timer > 0) timer--;
    if (timer != 0) return;
    armed = 0;
    case (pstate)
      tlpm_pkg::ST_OFF: begin
        r.action = tlpm_pkg::ACT_PWR_UP; go(tlpm_pkg::ST_SYNC, cfg.sync_wait_timeout);
        vlevel = tlpm_pkg::VS_DOWN;
      end
      tlpm_pkg::ST_SYNC: begin
        r.action = tlpm_pkg::ACT_PWR_DN; go(tlpm_pkg::ST_OFF, tlpm_pkg::T_OFF_WAIT);
        vlevel = tlpm_pkg::VS_DOWN;
      end
      tlpm_pkg::ST_REST:
        if (qempty) begin
          r.action = tlpm_pkg::ACT_POLL; go(tlpm_pkg::ST_ASK, 12'(cfg.ack_timeout));
        end else begin
          r.action = tlpm_pkg::ACT_START; go(tlpm_pkg::ST_SEND, cfg.transmit_timeout);
        end
      tlpm_pkg::ST_ASK, tlpm_pkg::ST_LEN2, tlpm_pkg::ST_BODY: begin
        tmo_up(); go(tlpm_pkg::ST_REST, idle_time());
      end
      tlpm_pkg::ST_ACKW: begin
        tmo_up(); r.action = tlpm_pkg::ACT_RESTART; go(tlpm_pkg::ST_REST, idle_time());
      end
      default: r.action = tlpm_pkg::ACT_FREEZE;
    endcase
  endfunction

  function void line(bit sig, bit sync);
    if (pstate == tlpm_pkg::ST_OFF) begin
      if (sig) begin
        r.action = tlpm_pkg::ACT_PWR_UP; go(tlpm_pkg::ST_SYNC, tlpm_pkg::T_LINE_WAIT);
        vlevel = tlpm_pkg::VS_DOWN;
      end
    end else if (pstate == tlpm_pkg::ST_SYNC) begin
      if (!sig) begin
        r.action = tlpm_pkg::ACT_PWR_DN; go(tlpm_pkg::ST_OFF, tlpm_pkg::T_OFF_WAIT);
        vlevel = tlpm_pkg::VS_DOWN;
      end else if (sync) begin
        r.link_event = tlpm_pkg::EV_SYNC; go(tlpm_pkg::ST_REST, tlpm_pkg::T_LINE_WAIT);
        vlevel = tlpm_pkg::VS_HALF;
      end
    end else if (!sync) begin
      r.link_event = tlpm_pkg::EV_LOST;
      if (sig) go(tlpm_pkg::ST_SYNC, tlpm_pkg::T_LINE_WAIT);
      else begin
        r.action = tlpm_pkg::ACT_PWR_DN; go(tlpm_pkg::ST_OFF, tlpm_pkg::T_OFF_WAIT);
      end
      vlevel = tlpm_pkg::VS_DOWN;
    end
  endfunction

  // note an accepted event and queue its predicted result
  function void note_event(tlpm_pkg::in_item_t e);
    r = '0;
    case (e.req_type)
      tlpm_pkg::REQ_OCTET: octet(e.rx_octet, e.in_call);
      tlpm_pkg::REQ_TICK:  tick(e.tx_queue_empty, e.tx_idle);
      tlpm_pkg::REQ_LINE:  line(e.line_signal, e.loop_in_sync);
      default: ;
    endcase
    if (r.payload_valid) payload_beats++;
    r.verbose_state = vlevel;
    r.link_state = pstate;
    r.fault_count = faults[15:0];
    r.timeout_count = tmos[15:0];
    pending.push_back(r);
  endfunction

  function void report(string f, int unsigned x, int unsigned a);
    if (errors < 10) $display("mismatch on %s: expected %0d got %0d", f, x, a);
    errors++;
  endfunction

  // compare a result beat with the oldest prediction
  function void check_result(tlpm_pkg::out_item_t a);
    tlpm_pkg::out_item_t x;
    checked++;
    if (pending.size() == 0) begin
      if (errors < 10) $display("result beat with no prediction waiting");
      errors++;
      return;
    end
    x = pending.pop_front();
    if (a.action !== x.action) report("action", x.action, a.action);
    if (a.link_event !== x.link_event) report("link_event", x.link_event, a.link_event);
    if (a.payload_valid !== x.payload_valid)
      report("payload_valid", x.payload_valid, a.payload_valid);
    if (a.payload_byte !== x.payload_byte) report("payload_byte", x.payload_byte, a.payload_byte);
    if (a.payload_index !== x.payload_index)
      report("payload_index", x.payload_index, a.payload_index);
    if (a.packet_result !== x.packet_result)
      report("packet_result", x.packet_result, a.packet_result);
    if (a.verbose_state !== x.verbose_state)
      report("verbose_state", x.verbose_state, a.verbose_state);
    if (a.link_state !== x.link_state) report("link_state", x.link_state, a.link_state);
    if (a.fault_count !== x.fault_count) report("fault_count", x.fault_count, a.fault_count);
    if (a.timeout_count !== x.timeout_count)
      report("timeout_count", x.timeout_count, a.timeout_count);
  endfunction
endclass

module tb_top;
  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  tlpm_pkg::in_item_t in_data;
  tlpm_pkg::out_item_t out_data;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  link_scoreboard sb;
  int unsigned cycles;
  int unsigned events_sent;
  int hold_cycles;
  bit hold_on;

  telephone_link_poll_master_unit u_top (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result tap
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver stalls: random gaps plus a long forced hold
  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else if (hold_on) out_stall <= 1;
    else if ($urandom_range(0, 3) == 0) out_stall <= ($urandom_range(0, 9) != 0);
    else out_stall <= 0;
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      tlpm_pkg::REG_POLL:  sb.cfg.idle_ticks = v[7:0];
      tlpm_pkg::REG_ACK:   sb.cfg.ack_timeout = v[7:0];
      tlpm_pkg::REG_OCTET: sb.cfg.octet_timeout = v[7:0];
      tlpm_pkg::REG_FAST:  sb.cfg.fast_poll_timeout = v[7:0];
      tlpm_pkg::REG_TX:    sb.cfg.transmit_timeout = v[11:0];
      tlpm_pkg::REG_SYNCW: sb.cfg.sync_wait_timeout = v[11:0];
      tlpm_pkg::REG_STAT:  sb.cfg.status_func_code = v[7:0];
      default:             sb.cfg.test_result_func_code = v[7:0];
    endcase
  endtask

  // offer one beat, with an optional random gap first; note it when accepted
  task automatic send(tlpm_pkg::in_item_t e, bit gaps);
    int g;
    if (gaps && $urandom_range(0, 2) == 0) begin
      g = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1; in_data <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_event(e);
    events_sent++;
  endtask

  task automatic idle_in();
    in_valid <= 0;
    @(posedge clk);
  endtask

  function automatic tlpm_pkg::in_item_t mk(logic [1:0] k, logic [7:0] b);
    tlpm_pkg::in_item_t e;
    e = tlpm_pkg::in_item_t'($urandom);
    e.req_type = k;
    e.rx_octet = b;
    return e;
  endfunction

  function automatic tlpm_pkg::in_item_t mk_line(bit sig, bit sync);
    tlpm_pkg::in_item_t e;
    e = mk(tlpm_pkg::REQ_LINE, 8'($urandom));
    e.line_signal = sig; e.loop_in_sync = sync;
    return e;
  endfunction

  function automatic tlpm_pkg::in_item_t mk_tick(bit qe, bit ti);
    tlpm_pkg::in_item_t e;
    e = mk(tlpm_pkg::REQ_TICK, 8'($urandom));
    e.tx_queue_empty = qe; e.tx_idle = ti;
    return e;
  endfunction

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ticks until the link is polled or the bounded count runs out
  task automatic tick_to_ask(bit gaps);
    int n;
    n = 0;
    while (sb.pstate != tlpm_pkg::ST_ASK && n < 300) begin
      send(mk_tick(1, 1'($urandom_range(0, 1))), gaps);
      n++;
    end
  endtask

  // one framed packet from the terminal, possibly with errors
  task automatic send_frame(bit gaps);
    int len;
    logic [7:0] s, b, fc;
    bit lng;
    lng = ($urandom_range(0, 5) == 0);
    len = lng ? $urandom_range(5, 304) : $urandom_range(4, 20);
    if (!lng && $urandom_range(0, 7) == 0) len = $urandom_range(21, 127);
    if (lng) begin
      b = {7'b1000000, len[8]};
      send(mk(tlpm_pkg::REQ_OCTET, b), gaps);
      s = b;
      send(mk(tlpm_pkg::REQ_OCTET, len[7:0]), gaps);
      s = s + len[7:0];
    end else begin
      send(mk(tlpm_pkg::REQ_OCTET, len[7:0]), gaps);
      s = len[7:0];
    end
    for (int i = lng ? 2 : 1; i < len - 1; i++) begin
      b = 8'($urandom);
      fc = $urandom_range(0, 1) ? sb.cfg.status_func_code : sb.cfg.test_result_func_code;
      if (i == (lng ? 3 : 2)) b = ($urandom_range(0, 2) == 0) ? 8'($urandom) : fc;
      if (i == (lng ? 4 : 3) && $urandom_range(0, 1)) b = tlpm_pkg::TEST_MARK;
      if ($urandom_range(0, 200) == 0) begin
        send(mk_tick(1, 0), gaps);
      end
      send(mk(tlpm_pkg::REQ_OCTET, b), gaps);
      s = s + b;
    end
    b = s - 8'd1;
    if ($urandom_range(0, 9) == 0) b = b ^ 8'($urandom_range(1, 255));
    send(mk(tlpm_pkg::REQ_OCTET, b), gaps);
  endtask

  // bring the link to idle through power up and loop sync
  task automatic bring_up(bit gaps);
    if (sb.pstate == tlpm_pkg::ST_OFF) send(mk_line(1, 0), gaps);
    if (sb.pstate == tlpm_pkg::ST_SYNC) send(mk_line(1, 1), gaps);
  endtask

  initial begin
    int r;
    sb = new();
    sb.reset_state();
    rst = 1; in_valid = 0; in_data = '0; psel = 0; penable = 0; pwrite = 0;
    paddr = '0; pwdata = '0; cycles = 0; hold_on = 0; hold_cycles = 0;
    events_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes of the timers, power cycle, idle, mode and bad-length octets
    reg_write(tlpm_pkg::REG_POLL, 1); reg_write(tlpm_pkg::REG_ACK, 255);
    reg_write(tlpm_pkg::REG_OCTET, 1); reg_write(tlpm_pkg::REG_FAST, 255);
    reg_write(tlpm_pkg::REG_TX, 1); reg_write(tlpm_pkg::REG_SYNCW, 4095);
    reg_write(tlpm_pkg::REG_STAT, 32'hFF); reg_write(tlpm_pkg::REG_TEST, 0);
    send(mk(2'd3, 8'hFF), 0);                // unknown request kind
    send(mk_tick(1, 1), 0);                  // disarmed timer
    send(mk_line(0, 0), 0);
    send(mk_line(1, 0), 0);                  // power up
    send(mk_line(0, 1), 0);                  // signal lost: power down
    send(mk_line(1, 1), 0);
    send(mk_line(1, 1), 0);                  // in sync
    send(mk(tlpm_pkg::REQ_OCTET, 8'h00), 0); // octet while idle
    tick_to_ask(0);
    send(mk(tlpm_pkg::REQ_OCTET, 8'h01), 0); // enhanced mode
    tick_to_ask(0);
    send(mk(tlpm_pkg::REQ_OCTET, 8'h02), 0); // bad length
    tick_to_ask(0);
    send(mk(tlpm_pkg::REQ_OCTET, tlpm_pkg::LEN_LONG1), 0);
    send(mk(tlpm_pkg::REQ_OCTET, 8'hFF), 0); // long length out of range
    tick_to_ask(0);
    send(mk(tlpm_pkg::REQ_OCTET, 8'hFF), 0);
    send(mk_line(0, 0), 0);                  // lost sync without signal
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      reg_write(tlpm_pkg::REG_POLL, ph == 5 ? 255 : $urandom_range(1, 6));
      reg_write(tlpm_pkg::REG_ACK, ph == 5 ? 255 : $urandom_range(1, 8));
      reg_write(tlpm_pkg::REG_OCTET, ph == 1 ? 1 : $urandom_range(2, 255));
      reg_write(tlpm_pkg::REG_FAST, $urandom_range(1, 4));
      reg_write(tlpm_pkg::REG_TX, ph == 2 ? 4095 : $urandom_range(1, 6));
      reg_write(tlpm_pkg::REG_SYNCW, $urandom_range(1, 8));
      reg_write(tlpm_pkg::REG_STAT, $urandom_range(0, 255));
      reg_write(tlpm_pkg::REG_TEST, ph == 0 ? 0 : $urandom_range(0, 255));
      while (events_sent < 30 + 215 * (ph + 1)) begin
        r = $urandom_range(0, 19);
        if (r == 0) send(mk(2'($urandom), 8'($urandom)), 1);
        else if (r == 1) begin
          send(mk_line(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))), 1);
        end else if (r < 4) begin
          send(mk_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))), 1);
        end else begin
          bring_up(1);
          tick_to_ask(1);
          if (sb.pstate == tlpm_pkg::ST_ASK) begin
            r = $urandom_range(0, 9);
            if (r < 7) send_frame(1);
            else if (r == 7) send(mk(tlpm_pkg::REQ_OCTET, 8'($urandom_range(0, 1))), 1);
            else send(mk(tlpm_pkg::REQ_OCTET, 8'($urandom)), 1);
          end
          // a transmit round with its ack
          if ($urandom_range(0, 2) == 0 && sb.pstate == tlpm_pkg::ST_REST) begin
            while (sb.pstate == tlpm_pkg::ST_REST) send(mk_tick(0, 0), 1);
            if (sb.pstate == tlpm_pkg::ST_SEND) begin
              send(mk_tick(0, 1), 1);
              send(mk(tlpm_pkg::REQ_OCTET,
                      $urandom_range(0, 3) != 0 ? tlpm_pkg::ACK_OCTET : 8'($urandom)), 1);
            end
          end
        end
        // long receiver hold while the sender keeps offering
        if (ph == 3 && !hold_on && hold_cycles == 0) begin
          hold_on = 1;
          fork
            begin
              repeat (60) @(posedge clk);
              hold_cycles = 60;
              hold_on = 0;
            end
          join_none
        end
      end
      // sender waits until everything has come back
      if (ph == 4) drain();
    end

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d events, %0d results checked, %0d payload beats, %0d good packets",
             events_sent, sb.checked, sb.payload_beats, sb.packets_done);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d predictions left", sb.errors, sb.pending.size());
      $display("simulation failed");
    end
    $finish;
  end
endmodule
